/* design/msenv_pkg.sv */
`default_nettype none

package msenv_pkg;

    // Default widths of the envelope datapath.
    localparam int LEVEL_BITS_DEF    = 16;
    localparam int COUNT_BITS_DEF    = 24;
    localparam int FRACTION_BITS_DEF = 16;

    // Register file layout.
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ATTACK_LEVEL_FIRST  = 3'd0,
        REG_ATTACK_LEVEL_SECOND = 3'd1,
        REG_ATTACK_LEN_FIRST    = 3'd2,
        REG_ATTACK_LEN_SECOND   = 3'd3,
        REG_SUSTAIN_LEN         = 3'd4,
        REG_RELEASE_LEVEL_FIRST = 3'd5,
        REG_RELEASE_LEN_FIRST   = 3'd6,
        REG_RELEASE_LEN_SECOND  = 3'd7
    } cfg_reg_t;

    // Reset values of the registers.
    localparam longint unsigned ATTACK_LEVEL_FIRST_RST  = 65535;
    localparam longint unsigned ATTACK_LEVEL_SECOND_RST = 45875;
    localparam longint unsigned ATTACK_LEN_FIRST_RST    = 4410;
    localparam longint unsigned ATTACK_LEN_SECOND_RST   = 8820;
    localparam longint unsigned SUSTAIN_LEN_RST         = 17640;
    localparam longint unsigned RELEASE_LEVEL_FIRST_RST = 13107;
    localparam longint unsigned RELEASE_LEN_FIRST_RST   = 4410;
    localparam longint unsigned RELEASE_LEN_SECOND_RST  = 8820;

    typedef enum logic [1:0] {
        STG_ATTACK  = 2'd0,
        STG_SUSTAIN = 2'd1,
        STG_RELEASE = 2'd2,
        STG_DONE    = 2'd3
    } stage_t;

    // Segment index within the attack or release phase.
    localparam logic [1:0] SEG_FIRST  = 2'd0;
    localparam logic [1:0] SEG_SECOND = 2'd1;
    localparam logic [1:0] SEG_NONE   = 2'd3;

    typedef enum logic {
        CTL_IDLE   = 1'b0,
        CTL_DIVIDE = 1'b1
    } ctrl_t;

endpackage

`default_nettype wire

/* design/multi_segment_envelope_fsm_top.sv */
`default_nettype none
// The result beat for a tick is registered and presented in the cycle after the tick beat is taken.
// A tick that does not open a new segment leaves the divider free for the next tick.
// A tick that opens an attack or release segment runs the shared restoring divider, one
// quotient bit per cycle, and s_ready stays low until the divider has finished.
// Reset (aresetn low at a clock edge) restores the register defaults and the envelope start state.
module multi_segment_envelope_fsm_top #(
    parameter int LEVEL_BITS    = msenv_pkg::LEVEL_BITS_DEF,
    parameter int COUNT_BITS    = msenv_pkg::COUNT_BITS_DEF,
    parameter int FRACTION_BITS = msenv_pkg::FRACTION_BITS_DEF
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    // Configuration write port.
    input  wire                                cfg_wr_en,
    input  wire  [msenv_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [((COUNT_BITS > LEVEL_BITS) ? COUNT_BITS : LEVEL_BITS)-1:0] cfg_wdata,
    // Tick input channel.
    input  wire                                s_valid,
    output logic                               s_ready,
    input  wire                                s_restart,
    // Result channel.
    output logic                               m_valid,
    input  wire                                m_ready,
    output logic [LEVEL_BITS-1:0]              m_level,
    output logic [1:0]                         m_stage
);

    // The level accumulator carries LEVEL_BITS integer bits above FRACTION_BITS fraction
    // bits. The step is one bit wider and signed. The tick counter is one bit wider than
    // a length so that it can go just below zero.
    localparam int ACC_W = LEVEL_BITS + FRACTION_BITS;
    localparam int STEP_W = ACC_W + 1;
    localparam int TC_W = COUNT_BITS + 1;
    localparam int CNT_W = $clog2(ACC_W + 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [LEVEL_BITS-1:0] atk_lvl1_reg;
    logic [LEVEL_BITS-1:0] atk_lvl2_reg;
    logic [COUNT_BITS-1:0] atk_len1_reg;
    logic [COUNT_BITS-1:0] atk_len2_reg;
    logic [COUNT_BITS-1:0] sus_len_reg;
    logic [LEVEL_BITS-1:0] rel_lvl1_reg;
    logic [COUNT_BITS-1:0] rel_len1_reg;
    logic [COUNT_BITS-1:0] rel_len2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            atk_lvl1_reg <= LEVEL_BITS'(msenv_pkg::ATTACK_LEVEL_FIRST_RST);
            atk_lvl2_reg <= LEVEL_BITS'(msenv_pkg::ATTACK_LEVEL_SECOND_RST);
            atk_len1_reg <= COUNT_BITS'(msenv_pkg::ATTACK_LEN_FIRST_RST);
            atk_len2_reg <= COUNT_BITS'(msenv_pkg::ATTACK_LEN_SECOND_RST);
            sus_len_reg  <= COUNT_BITS'(msenv_pkg::SUSTAIN_LEN_RST);
            rel_lvl1_reg <= LEVEL_BITS'(msenv_pkg::RELEASE_LEVEL_FIRST_RST);
            rel_len1_reg <= COUNT_BITS'(msenv_pkg::RELEASE_LEN_FIRST_RST);
            rel_len2_reg <= COUNT_BITS'(msenv_pkg::RELEASE_LEN_SECOND_RST);
        end else if (cfg_wr_en) begin
            unique case (msenv_pkg::cfg_reg_t'(cfg_index))
                msenv_pkg::REG_ATTACK_LEVEL_FIRST:  atk_lvl1_reg <= cfg_wdata[LEVEL_BITS-1:0];
                msenv_pkg::REG_ATTACK_LEVEL_SECOND: atk_lvl2_reg <= cfg_wdata[LEVEL_BITS-1:0];
                msenv_pkg::REG_ATTACK_LEN_FIRST:    atk_len1_reg <= cfg_wdata[COUNT_BITS-1:0];
                msenv_pkg::REG_ATTACK_LEN_SECOND:   atk_len2_reg <= cfg_wdata[COUNT_BITS-1:0];
                msenv_pkg::REG_SUSTAIN_LEN:         sus_len_reg  <= cfg_wdata[COUNT_BITS-1:0];
                msenv_pkg::REG_RELEASE_LEVEL_FIRST: rel_lvl1_reg <= cfg_wdata[LEVEL_BITS-1:0];
                msenv_pkg::REG_RELEASE_LEN_FIRST:   rel_len1_reg <= cfg_wdata[COUNT_BITS-1:0];
                msenv_pkg::REG_RELEASE_LEN_SECOND:  rel_len2_reg <= cfg_wdata[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Envelope state
    // ------------------------------------------------------------------
    msenv_pkg::stage_t        stage_reg, stage_next;
    logic [1:0]               seg_reg, seg_next;
    logic signed [TC_W-1:0]   tc_reg, tc_next;
    logic [ACC_W-1:0]         acc_reg, acc_next;
    logic [LEVEL_BITS-1:0]    tgt_reg, tgt_next;
    logic signed [STEP_W-1:0] step_reg, step_next;

    // Control of the shared divider and the output register.
    msenv_pkg::ctrl_t         ctrl_reg, ctrl_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [COUNT_BITS-1:0]    rem_reg, rem_next;
    logic [ACC_W-1:0]         dvd_reg, dvd_next;
    logic [COUNT_BITS-1:0]    divisor_reg, divisor_next;
    logic                     down_reg, down_next;
    logic                     m_valid_reg, m_valid_next;
    logic [LEVEL_BITS-1:0]    level_out_reg, level_out_next;
    msenv_pkg::stage_t        stage_out_reg, stage_out_next;

    logic                     tick_acc;
    logic                     start_div;
    logic [COUNT_BITS-1:0]    start_len;
    logic [ACC_W-1:0]         start_mag;
    logic                     start_down;

    // Divider datapath: one restoring step per cycle.
    logic [COUNT_BITS:0]      rem_shift;
    logic [COUNT_BITS+1:0]    trial;
    logic                     trial_ge;
    logic [COUNT_BITS-1:0]    rem_step;
    logic [ACC_W-1:0]         quot_step;
    logic signed [STEP_W-1:0] quot_signed;

    assign tick_acc = s_valid && s_ready;

    // ------------------------------------------------------------------
    // One tick of the envelope. A restart beat first takes the envelope back to
    // its start state and then runs the tick as usual. Every field except the
    // step of a freshly opened segment is settled here; that step comes out of
    // the divider afterwards, and it is first used by the following tick.
    // ------------------------------------------------------------------
    always_comb begin
        msenv_pkg::stage_t        e_stage;
        logic [1:0]               e_seg;
        logic signed [TC_W-1:0]   e_tc;
        logic [ACC_W-1:0]         e_acc;
        logic [LEVEL_BITS-1:0]    e_tgt;
        logic signed [STEP_W-1:0] e_step;
        logic signed [TC_W-1:0]   tc_dec;
        logic                     seg_end;
        logic [1:0]               seg_inc;
        logic [ACC_W-1:0]         acc_sum;
        logic [ACC_W-1:0]         tgt_scaled;
        logic [LEVEL_BITS-1:0]    new_tgt;
        logic [COUNT_BITS-1:0]    new_len;
        logic [ACC_W-1:0]         goal;

        if (s_restart) begin
            e_stage = msenv_pkg::STG_ATTACK;
            e_seg   = msenv_pkg::SEG_NONE;
            e_tc    = '0;
            e_acc   = '0;
            e_tgt   = '0;
            e_step  = '0;
        end else begin
            e_stage = stage_reg;
            e_seg   = seg_reg;
            e_tc    = tc_reg;
            e_acc   = acc_reg;
            e_tgt   = tgt_reg;
            e_step  = step_reg;
        end

        tc_dec     = e_tc - TC_W'(1);
        seg_end    = tc_dec[TC_W-1] || (tc_dec == '0);
        seg_inc    = e_seg + 2'd1;
        acc_sum    = e_acc + e_step[ACC_W-1:0];
        tgt_scaled = {e_tgt, {FRACTION_BITS{1'b0}}};

        stage_next = e_stage;
        seg_next   = e_seg;
        tc_next    = e_tc;
        acc_next   = e_acc;
        tgt_next   = e_tgt;
        step_next  = e_step;
        start_div  = 1'b0;
        new_tgt    = '0;
        new_len    = '0;

        unique case (e_stage)
            msenv_pkg::STG_ATTACK, msenv_pkg::STG_RELEASE: begin
                tc_next = tc_dec;
                if (seg_end) begin
                    // Land exactly on the target of the segment that has ended.
                    acc_next = tgt_scaled;
                    seg_next = seg_inc;
                    if (e_stage == msenv_pkg::STG_ATTACK) begin
                        if (seg_inc == msenv_pkg::SEG_FIRST) begin
                            start_div = 1'b1;
                            new_tgt   = atk_lvl1_reg;
                            new_len   = atk_len1_reg;
                        end else if (seg_inc == msenv_pkg::SEG_SECOND) begin
                            start_div = 1'b1;
                            new_tgt   = atk_lvl2_reg;
                            new_len   = atk_len2_reg;
                        end else begin
                            tc_next    = $signed({1'b0, sus_len_reg});
                            step_next  = '0;
                            stage_next = msenv_pkg::STG_SUSTAIN;
                        end
                    end else begin
                        if (seg_inc == msenv_pkg::SEG_FIRST) begin
                            start_div = 1'b1;
                            new_tgt   = rel_lvl1_reg;
                            new_len   = rel_len1_reg;
                        end else if (seg_inc == msenv_pkg::SEG_SECOND) begin
                            start_div = 1'b1;
                            new_tgt   = '0;
                            new_len   = rel_len2_reg;
                        end else begin
                            tc_next    = '0;
                            step_next  = '0;
                            acc_next   = '0;
                            stage_next = msenv_pkg::STG_DONE;
                        end
                    end
                end else begin
                    acc_next = acc_sum;
                end
            end
            msenv_pkg::STG_SUSTAIN: begin
                tc_next = tc_dec;
                if (seg_end) begin
                    seg_next   = msenv_pkg::SEG_NONE;
                    stage_next = msenv_pkg::STG_RELEASE;
                end
            end
            default: ;
        endcase

        // Opening a segment: a zero length counts as a single tick, and the
        // distance to the new target is handed to the divider as a magnitude.
        if (new_len == '0) begin
            new_len = COUNT_BITS'(1);
        end
        goal       = {new_tgt, {FRACTION_BITS{1'b0}}};
        start_len  = new_len;
        start_down = goal < acc_next;
        start_mag  = start_down ? (acc_next - goal) : (goal - acc_next);
        if (start_div) begin
            tgt_next = new_tgt;
            tc_next  = $signed({1'b0, new_len});
        end
    end

    // ------------------------------------------------------------------
    // Shared restoring divider step.
    // ------------------------------------------------------------------
    assign rem_shift   = {rem_reg, dvd_reg[ACC_W-1]};
    assign trial       = {1'b0, rem_shift} - {2'b00, divisor_reg};
    assign trial_ge    = !trial[COUNT_BITS+1];
    assign rem_step    = trial_ge ? trial[COUNT_BITS-1:0] : rem_shift[COUNT_BITS-1:0];
    assign quot_step   = {dvd_reg[ACC_W-2:0], trial_ge};
    assign quot_signed = down_reg ? -$signed({1'b0, quot_step}) : $signed({1'b0, quot_step});

    // A tick is taken only while the divider is free and the result slot is
    // empty or being emptied in the same cycle.
    assign s_ready = (ctrl_reg == msenv_pkg::CTL_IDLE) && (!m_valid_reg || m_ready);

    always_comb begin
        ctrl_next      = ctrl_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        divisor_next   = divisor_reg;
        down_next      = down_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        level_out_next = level_out_reg;
        stage_out_next = stage_out_reg;

        unique case (ctrl_reg)
            msenv_pkg::CTL_IDLE: begin
                if (tick_acc) begin
                    m_valid_next   = 1'b1;
                    level_out_next = acc_next[ACC_W-1:FRACTION_BITS];
                    stage_out_next = stage_next;
                    if (start_div) begin
                        ctrl_next    = msenv_pkg::CTL_DIVIDE;
                        cnt_next     = CNT_W'(ACC_W);
                        rem_next     = '0;
                        dvd_next     = start_mag;
                        divisor_next = start_len;
                        down_next    = start_down;
                    end
                end
            end
            msenv_pkg::CTL_DIVIDE: begin
                rem_next = rem_step;
                dvd_next = quot_step;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    ctrl_next = msenv_pkg::CTL_IDLE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg    <= msenv_pkg::CTL_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            stage_reg   <= msenv_pkg::STG_ATTACK;
            seg_reg     <= msenv_pkg::SEG_NONE;
            tc_reg      <= '0;
            acc_reg     <= '0;
            tgt_reg     <= '0;
            step_reg    <= '0;
        end else begin
            ctrl_reg    <= ctrl_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (tick_acc) begin
                stage_reg <= stage_next;
                seg_reg   <= seg_next;
                tc_reg    <= tc_next;
                acc_reg   <= acc_next;
                tgt_reg   <= tgt_next;
                step_reg  <= step_next;
            end else if (ctrl_reg == msenv_pkg::CTL_DIVIDE && cnt_reg == CNT_W'(1)) begin
                step_reg <= quot_signed;
            end
        end
    end

    // Datapath registers of the divider and the result slot.
    always_ff @(posedge aclk) begin
        rem_reg       <= rem_next;
        dvd_reg       <= dvd_next;
        divisor_reg   <= divisor_next;
        down_reg      <= down_next;
        level_out_reg <= level_out_next;
        stage_out_reg <= stage_out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_level = level_out_reg;
    assign m_stage = stage_out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_done_is_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_reg == msenv_pkg::STG_DONE) |-> (acc_reg == '0))
        else $error("envelope finished with a non-zero level");

    a_sustain_flat: assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_reg == msenv_pkg::STG_SUSTAIN) |-> (step_reg == '0))
        else $error("sustain holds a non-zero step");

    a_div_count_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl_reg == msenv_pkg::CTL_DIVIDE) |-> (cnt_reg != '0))
        else $error("divider running with an exhausted bit count");

    a_div_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl_reg == msenv_pkg::CTL_DIVIDE) |-> (rem_reg < divisor_reg))
        else $error("divider remainder not below the divisor");

endmodule

`default_nettype wire
